/* rtl/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg: shared constants for the layered pixel compositor
// Operation codes, register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_LAYERS     = 8;

  // field widths
  localparam int OP_W    = 3;
  localparam int COORD_W = 11;
  localparam int LAYER_W = 4;
  localparam int COLOR_W = 9;
  localparam int VALUE_W = 9;
  localparam int DRAW_W  = 9;
  localparam int PIX_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // compare widths: coordinates against caps up to 2048, layer counts up to 16
  localparam int CMP_W = 12;
  localparam int NL_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_LAYER_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_DIRECT_DRAW = 3'd1;
  localparam logic [OP_W-1:0] OP_LAYER_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_COMP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_OCC_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAYERS    = 2'd3;

  // register reset values
  localparam logic [9:0] RST_ACTIVE_WIDTH  = 10'd512;
  localparam logic [9:0] RST_ACTIVE_HEIGHT = 10'd512;
  localparam logic [8:0] RST_NUM_COLORS    = 9'd256;
  localparam logic [3:0] RST_NUM_LAYERS    = 4'd8;

  // pixel codes
  localparam logic [PIX_W-1:0]   TRANSPARENT    = 8'hFF;
  localparam logic [PIX_W-1:0]   SHADOW_BLANK   = 8'h00;
  localparam logic [VALUE_W-1:0] VALUE_TRANSP   = 9'h1FF;

endpackage

`default_nettype wire

/* rtl/layered_pixel_compositor_unit.sv */
// ----------------------------------------------------------------------------
// layered_pixel_compositor_unit: layered framebuffer compositor
// Layer planes plus shadow screen in one row-per-pixel RAM; a small sequencer
// walks the layers through one shared transparency compare.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//  req     | in        | req_valid / req_stall| op, x, y, layer, color
//  rsp     | out       | rsp_valid / rsp_stall| status, read_value, draw_valid,
//          |           |                      | draw_x, draw_y, draw_color,
//          |           |                      | clear_display
//
// Errors and direct draw go straight to the reply; a layer read fetches the
// row and picks one lane; composite and occupancy reads and layer writes fetch
// the row and scan the layers in use, one layer per cycle through the shared
// compare, and a layer write then writes the row back. Clear sweeps one RAM
// row a cycle. After reset the same sweep runs with req_stall high;
// configuration writes are taken all the while.
// A finished word waits in the output register; a new request is taken while
// it waits, and the next reply waits until rsp_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module layered_pixel_compositor_unit #(
  parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT,
  parameter int LAYERS     = lpc_pkg::DEF_LAYERS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [lpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lpc_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request channel
  input  wire logic                                 req_valid,
  output logic                                      req_stall,
  input  wire logic [lpc_pkg::OP_W-1:0]             op,
  input  wire logic signed [lpc_pkg::COORD_W-1:0]   x,
  input  wire logic signed [lpc_pkg::COORD_W-1:0]   y,
  input  wire logic [lpc_pkg::LAYER_W-1:0]          layer,
  input  wire logic signed [lpc_pkg::COLOR_W-1:0]   color,
  // response channel
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_stall,
  output logic                                      status,
  output logic signed [lpc_pkg::VALUE_W-1:0]        read_value,
  output logic                                      draw_valid,
  output logic [lpc_pkg::DRAW_W-1:0]                draw_x,
  output logic [lpc_pkg::DRAW_W-1:0]                draw_y,
  output logic [lpc_pkg::PIX_W-1:0]                 draw_color,
  output logic                                      clear_display
);

  localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(PLANE);
  localparam int ROW_W = (LAYERS + 1) * lpc_pkg::PIX_W;
  localparam int LIW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(PLANE - 1);

  typedef enum logic [2:0] {
    ST_SWEEP,   // writing the reset row everywhere
    ST_IDLE,    // ready for a request
    ST_FETCH,   // RAM read of the pixel row in flight
    ST_LOAD,    // capture row, merge a layer write
    ST_SCAN,    // walk layers top-down through the compare
    ST_PICK,    // single layer read
    ST_WRITE,   // write the row back
    ST_REPLY    // hand result to the output register
  } state_t;

  state_t state;

  // configuration registers
  logic [9:0] active_width;
  logic [9:0] active_height;
  logic [8:0] num_colors;
  logic [3:0] num_layers;

  // working registers
  logic [lpc_pkg::OP_W-1:0]   op_r;
  logic [lpc_pkg::DRAW_W-1:0] x_r;
  logic [lpc_pkg::DRAW_W-1:0] y_r;
  logic [LIW-1:0]             layer_r;
  logic [lpc_pkg::PIX_W-1:0]  color_r;
  logic [AW-1:0]              pix_r;
  logic [LIW-1:0]             idx;
  logic [LAYERS-1:0]          mask;
  logic [lpc_pkg::PIX_W-1:0]  lanes [LAYERS];
  logic [lpc_pkg::PIX_W-1:0]  shadow;
  logic [AW-1:0]              sweep_cnt;
  logic                       sweep_reply;
  logic                       display_touched;

  // pending result
  logic                       res_status;
  logic [lpc_pkg::VALUE_W-1:0] res_value;
  logic                       res_draw;
  logic [lpc_pkg::PIX_W-1:0]  res_color;
  logic                       res_clear;

  // ---- argument checks on the request port ----
  logic [lpc_pkg::CMP_W-1:0] w_raw, h_raw, w_eff, h_eff, xpos, ypos;
  logic [lpc_pkg::NL_W-1:0]  nl_raw, nl_eff;
  logic signed [9:0]         color_x, ncol_x;
  logic                      xy_ok, layer_ok, wcol_ok, dcol_ok;
  logic [AW-1:0]             pix_in;

  always_comb begin
    w_raw   = {2'b00, active_width};
    h_raw   = {2'b00, active_height};
    w_eff   = (w_raw > lpc_pkg::CMP_W'(MAX_WIDTH)) ? lpc_pkg::CMP_W'(MAX_WIDTH) : w_raw;
    h_eff   = (h_raw > lpc_pkg::CMP_W'(MAX_HEIGHT)) ? lpc_pkg::CMP_W'(MAX_HEIGHT) : h_raw;
    xpos    = {1'b0, x};
    ypos    = {1'b0, y};
    xy_ok   = !x[lpc_pkg::COORD_W-1] && !y[lpc_pkg::COORD_W-1] &&
              (xpos < w_eff) && (ypos < h_eff);
    nl_raw  = {1'b0, num_layers};
    nl_eff  = (nl_raw > lpc_pkg::NL_W'(LAYERS)) ? lpc_pkg::NL_W'(LAYERS) : nl_raw;
    layer_ok = {1'b0, layer} < nl_eff;
    color_x = {color[lpc_pkg::COLOR_W-1], color};
    ncol_x  = {1'b0, num_colors};
    wcol_ok = (color_x >= -10'sd1) && (color_x < ncol_x);
    dcol_ok = !color[lpc_pkg::COLOR_W-1] && (color_x < ncol_x);
    // fixed row stride of MAX_WIDTH
    pix_in  = AW'(32'(ypos) * 32'(MAX_WIDTH) + 32'(xpos));
  end

  // ---- RAM: one row per pixel, lanes for every layer plus the shadow byte ----
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [lpc_pkg::PIX_W-1:0] ram_lane [LAYERS];

  always_comb begin
    ram_we    = (state == ST_SWEEP) || (state == ST_WRITE);
    ram_waddr = (state == ST_SWEEP) ? sweep_cnt : pix_r;
    ram_wdata = '0;
    for (int i = 0; i < LAYERS; i++) begin
      ram_wdata[lpc_pkg::PIX_W*(i+1) +: lpc_pkg::PIX_W] =
        (state == ST_SWEEP) ? lpc_pkg::TRANSPARENT : lanes[i];
      ram_lane[i] = ram_rdata[lpc_pkg::PIX_W*(i+1) +: lpc_pkg::PIX_W];
    end
    ram_wdata[lpc_pkg::PIX_W-1:0] = (state == ST_SWEEP) ? lpc_pkg::SHADOW_BLANK : shadow;
  end

  lpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PLANE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_r),
    .rdata (ram_rdata)
  );

  // ---- shared compare: is the selected lane opaque ----
  logic [lpc_pkg::PIX_W-1:0] lane_sel;
  logic                      opaque;
  logic                      scan_last;
  logic [lpc_pkg::PIX_W-1:0] comp_fin;
  logic [LAYERS-1:0]         mask_fin;

  always_comb begin
    lane_sel  = lanes[idx];
    opaque    = (lane_sel != lpc_pkg::TRANSPARENT);
    // occupancy visits every layer in use; composite and layer write stop at the first opaque one
    scan_last = (idx == '0) || ((op_r != lpc_pkg::OP_OCC_READ) && opaque);
    comp_fin  = opaque ? lane_sel : lpc_pkg::SHADOW_BLANK;
    mask_fin  = mask | (opaque ? (LAYERS'(1) << idx) : '0);
  end

  assign req_stall = (state != ST_IDLE);

  // output register loads when the reply is ready and the slot is free or leaving
  logic reply_fire;
  assign reply_fire = (state == ST_REPLY) && (!rsp_valid || !rsp_stall);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_SWEEP;
      sweep_cnt       <= '0;
      sweep_reply     <= 1'b0;
      rsp_valid       <= 1'b0;
      display_touched <= 1'b0;
      active_width    <= lpc_pkg::RST_ACTIVE_WIDTH;
      active_height   <= lpc_pkg::RST_ACTIVE_HEIGHT;
      num_colors      <= lpc_pkg::RST_NUM_COLORS;
      num_layers      <= lpc_pkg::RST_NUM_LAYERS;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lpc_pkg::CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[9:0];
          lpc_pkg::CFG_ACTIVE_HEIGHT: active_height <= cfg_data[9:0];
          lpc_pkg::CFG_NUM_COLORS:    num_colors    <= cfg_data[8:0];
          lpc_pkg::CFG_NUM_LAYERS:    num_layers    <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (reply_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_SWEEP: begin
          if (sweep_cnt == LAST_ROW) begin
            state <= sweep_reply ? ST_REPLY : ST_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end

        ST_IDLE: begin
          if (req_valid) begin
            op_r       <= op;
            x_r        <= x[lpc_pkg::DRAW_W-1:0];
            y_r        <= y[lpc_pkg::DRAW_W-1:0];
            layer_r    <= layer[LIW-1:0];
            color_r    <= color[lpc_pkg::PIX_W-1:0];
            pix_r      <= pix_in;
            res_status <= 1'b0;
            res_value  <= '0;
            res_draw   <= 1'b0;
            res_color  <= '0;
            res_clear  <= 1'b0;
            case (op)
              lpc_pkg::OP_LAYER_WRITE: begin
                if (xy_ok && layer_ok && wcol_ok) begin
                  state <= ST_FETCH;
                end else begin
                  res_status <= 1'b1;
                  state      <= ST_REPLY;
                end
              end
              lpc_pkg::OP_DIRECT_DRAW: begin
                if (xy_ok && dcol_ok) begin
                  display_touched <= 1'b1;
                  res_draw        <= 1'b1;
                  res_color       <= color[lpc_pkg::PIX_W-1:0];
                end else begin
                  res_status <= 1'b1;
                end
                state <= ST_REPLY;
              end
              lpc_pkg::OP_LAYER_READ: begin
                if (xy_ok && layer_ok) begin
                  state <= ST_FETCH;
                end else begin
                  res_status <= 1'b1;
                  state      <= ST_REPLY;
                end
              end
              lpc_pkg::OP_COMP_READ, lpc_pkg::OP_OCC_READ: begin
                if (xy_ok) begin
                  state <= ST_FETCH;
                end else begin
                  res_status <= 1'b1;
                  state      <= ST_REPLY;
                end
              end
              lpc_pkg::OP_CLEAR: begin
                res_clear       <= display_touched;
                display_touched <= 1'b0;
                sweep_cnt       <= '0;
                sweep_reply     <= 1'b1;
                state           <= ST_SWEEP;
              end
              default: begin
                res_status <= 1'b1;
                state      <= ST_REPLY;
              end
            endcase
          end
        end

        ST_FETCH: begin
          state <= ST_LOAD;
        end

        ST_LOAD: begin
          for (int i = 0; i < LAYERS; i++) begin
            lanes[i] <= ((op_r == lpc_pkg::OP_LAYER_WRITE) && (layer_r == LIW'(i))) ?
                        color_r : ram_lane[i];
          end
          shadow <= ram_rdata[lpc_pkg::PIX_W-1:0];
          mask   <= '0;
          if (op_r == lpc_pkg::OP_LAYER_READ) begin
            idx   <= layer_r;
            state <= ST_PICK;
          end else if (nl_eff == '0) begin
            // no layer in use: composite and occupancy both read 0
            state <= ST_REPLY;
          end else begin
            idx   <= LIW'(nl_eff - 1'b1);
            state <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          mask <= mask_fin;
          if (scan_last) begin
            case (op_r)
              lpc_pkg::OP_COMP_READ: begin
                res_value <= {1'b0, comp_fin};
                state     <= ST_REPLY;
              end
              lpc_pkg::OP_OCC_READ: begin
                res_value <= lpc_pkg::VALUE_W'(mask_fin);
                state     <= ST_REPLY;
              end
              default: begin
                // layer write: repaint only when the composite changed
                if (shadow != comp_fin) begin
                  shadow    <= comp_fin;
                  res_draw  <= 1'b1;
                  res_color <= comp_fin;
                end
                state <= ST_WRITE;
              end
            endcase
          end else begin
            idx <= idx - 1'b1;
          end
        end

        ST_PICK: begin
          res_value <= opaque ? {1'b0, lane_sel} : lpc_pkg::VALUE_TRANSP;
          state     <= ST_REPLY;
        end

        ST_WRITE: begin
          state <= ST_REPLY;
        end

        ST_REPLY: begin
          if (reply_fire) begin
            status        <= res_status;
            read_value    <= res_value;
            draw_valid    <= res_draw;
            draw_x        <= res_draw ? x_r : '0;
            draw_y        <= res_draw ? y_r : '0;
            draw_color    <= res_color;
            clear_display <= res_clear;
            sweep_reply   <= 1'b0;
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/lpc_ram.sv */
// ----------------------------------------------------------------------------
// lpc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/lpc_checker.sv */
// ----------------------------------------------------------------------------
// lpc_checker: port-level checks for the layered pixel compositor
// Watches request and response words; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_stall,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_stall,
  input wire logic                               status,
  input wire logic signed [lpc_pkg::VALUE_W-1:0] read_value,
  input wire logic                               draw_valid,
  input wire logic [lpc_pkg::DRAW_W-1:0]         draw_x,
  input wire logic [lpc_pkg::DRAW_W-1:0]         draw_y,
  input wire logic [lpc_pkg::PIX_W-1:0]          draw_color,
  input wire logic                               clear_display
);

  // one request at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in progress");

  // an error word carries nothing else
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> read_value == '0 && !draw_valid && draw_x == '0 &&
                            draw_y == '0 && draw_color == '0 && !clear_display)
    else $error("error response with nonzero fields");

  // draw requests and read results never share a word
  a_draw_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && draw_valid |-> read_value == '0 && !clear_display && !status)
    else $error("draw request mixed with read or clear result");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_value) &&
                               $stable(draw_valid) && $stable(draw_color) &&
                               $stable(status) && $stable(clear_display))
    else $error("stalled response changed");

endmodule

bind layered_pixel_compositor_unit lpc_checker u_lpc_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for layered_pixel_compositor_unit
// A directed table, then random phases under several register settings and
// handshake idle patterns. Each reply word is checked against its table row
// or a local model of layer planes, shadow screen and draw/clear logic.
// ----------------------------------------------------------------------------

module tb_top;
  import lpc_pkg::*;

  localparam int PLANE           = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT     = 4_000_000;  // room for the reset sweep, two clears and the traffic
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES     = 50;
  localparam int NUM_PHASES      = 9;

  // opcodes the block does not define
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one request word
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LAYER_W-1:0]        layer;
    logic signed [COLOR_W-1:0] color;
  } pix_cmd_t;

  // one reply word
  typedef struct packed {
    logic                      status;
    logic [VALUE_W-1:0]        read_value;
    logic                      draw_valid;
    logic [DRAW_W-1:0]         draw_x;
    logic [DRAW_W-1:0]         draw_y;
    logic [PIX_W-1:0]          draw_color;
    logic                      clear_display;
  } pix_reply_t;

  typedef struct {
    pix_cmd_t   cmd;
    bit         typed;   // reply below is fixed, else the model decides
    pix_reply_t reply;
  } dir_row_t;

  localparam pix_reply_t ERR_REPLY = '{status: 1'b1, default: '0};

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic [OP_W-1:0]           op = '0;
  logic signed [COORD_W-1:0] x = '0;
  logic signed [COORD_W-1:0] y = '0;
  logic [LAYER_W-1:0]        layer = '0;
  logic signed [COLOR_W-1:0] color = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic                      status;
  logic signed [VALUE_W-1:0] read_value;
  logic                      draw_valid;
  logic [DRAW_W-1:0]         draw_x;
  logic [DRAW_W-1:0]         draw_y;
  logic [PIX_W-1:0]          draw_color;
  logic                      clear_display;

  always #5 clk = ~clk;

  layered_pixel_compositor_unit dut (.*);

  // --------------------------------------------------------------------------
  // Model state. Planes and shadow are sparse: a missing key means the
  // reset value (transparent / blank), so a clear is just a delete.
  // --------------------------------------------------------------------------
  bit [PIX_W-1:0] layer_mem [int];
  bit [PIX_W-1:0] shadow_mem [int];
  bit             direct_drawn = 1'b0;   // a direct draw since the last clear

  // register copies, reset values
  int reg_width  = int'(RST_ACTIVE_WIDTH);
  int reg_height = int'(RST_ACTIVE_HEIGHT);
  int reg_colors = int'(RST_NUM_COLORS);
  int reg_layers = int'(RST_NUM_LAYERS);

  pix_reply_t expected_replies [$];
  int         mismatches = 0;

  // handshake idle percentages, set per phase
  int snd_pct = 0;
  int rcv_pct = 0;
  bit hold_rsp_req = 1'b0;

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit [PIX_W-1:0] layer_at(int key);
    return layer_mem.exists(key) ? layer_mem[key] : TRANSPARENT;
  endfunction

  function automatic bit [PIX_W-1:0] shadow_at(int pix);
    return shadow_mem.exists(pix) ? shadow_mem[pix] : SHADOW_BLANK;
  endfunction

  // topmost opaque layer among those in use, blank if none
  function automatic bit [PIX_W-1:0] composite_at(int pix, int nl);
    int i;
    for (i = nl - 1; i >= 0; i--)
      if (layer_at(i * PLANE + pix) != TRANSPARENT) return layer_at(i * PLANE + pix);
    return SHADOW_BLANK;
  endfunction

  // Apply one request to the model and return the reply it must produce.
  function automatic pix_reply_t composite_step(pix_cmd_t c);
    pix_reply_t     o;
    int             w, h, nl, nc, xi, yi, ci, li, pix, i;
    bit             xy_ok;
    bit [PIX_W-1:0] v;
    o  = '0;
    w  = clip(reg_width, DEF_MAX_WIDTH);
    h  = clip(reg_height, DEF_MAX_HEIGHT);
    nl = clip(reg_layers, DEF_LAYERS);
    nc = reg_colors;
    xi = int'($signed(c.x));
    yi = int'($signed(c.y));
    ci = int'($signed(c.color));
    li = int'(c.layer);
    xy_ok = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
    pix = xy_ok ? yi * DEF_MAX_WIDTH + xi : 0;
    case (c.op)
      OP_LAYER_WRITE: begin
        // -1 is legal here and lands as 255, same as writing 255
        if (!xy_ok || li >= nl || ci < -1 || ci >= nc) begin
          o.status = 1'b1;
        end else begin
          layer_mem[li * PLANE + pix] = ci[PIX_W-1:0];
          v = composite_at(pix, nl);
          if (shadow_at(pix) != v) begin
            shadow_mem[pix] = v;
            o.draw_valid = 1'b1;
            o.draw_color = v;
          end
        end
      end
      OP_DIRECT_DRAW: begin
        // shadow stays as is
        if (!xy_ok || ci < 0 || ci >= nc) begin
          o.status = 1'b1;
        end else begin
          direct_drawn = 1'b1;
          o.draw_valid = 1'b1;
          o.draw_color = ci[PIX_W-1:0];
        end
      end
      OP_LAYER_READ: begin
        if (!xy_ok || li >= nl) begin
          o.status = 1'b1;
        end else begin
          v = layer_at(li * PLANE + pix);
          o.read_value = (v == TRANSPARENT) ? VALUE_TRANSP : {1'b0, v};
        end
      end
      OP_COMP_READ: begin
        if (!xy_ok) o.status = 1'b1;
        else o.read_value = {1'b0, composite_at(pix, nl)};
      end
      OP_OCC_READ: begin
        if (!xy_ok) o.status = 1'b1;
        else
          for (i = 0; i < nl; i++)
            if (layer_at(i * PLANE + pix) != TRANSPARENT) o.read_value[i] = 1'b1;
      end
      OP_CLEAR: begin
        layer_mem.delete();
        shadow_mem.delete();
        o.clear_display = direct_drawn;
        direct_drawn = 1'b0;
      end
      default: o.status = 1'b1;
    endcase
    if (o.draw_valid) begin
      o.draw_x = c.x[DRAW_W-1:0];
      o.draw_y = c.y[DRAW_W-1:0];
    end
    return o;
  endfunction

  function automatic pix_cmd_t mk_cmd(logic [OP_W-1:0] o, int xv, int yv, int lv, int cv);
    pix_cmd_t c;
    c.op    = o;
    c.x     = xv[COORD_W-1:0];
    c.y     = yv[COORD_W-1:0];
    c.layer = lv[LAYER_W-1:0];
    c.color = cv[COLOR_W-1:0];
    return c;
  endfunction

  function automatic pix_reply_t mk_reply(int rv, bit dv, int dx, int dy, int dc, bit clr);
    pix_reply_t r;
    r.status        = 1'b0;
    r.read_value    = rv[VALUE_W-1:0];
    r.draw_valid    = dv;
    r.draw_x        = dx[DRAW_W-1:0];
    r.draw_y        = dy[DRAW_W-1:0];
    r.draw_color    = dc[PIX_W-1:0];
    r.clear_display = clr;
    return r;
  endfunction

  // Most coordinates crowd onto the two values at each end of the range so that layer
  // writes stack up on the same pixel; others spread over the range or probe the bounds.
  function automatic logic signed [COORD_W-1:0] pick_coord(int lim);
    int r, v;
    r = $urandom_range(99);
    if (lim > 0 && r < 60) begin
      v = $urandom_range(3);
      v = (v < 2) ? v : lim - 1 - (v - 2);
      if (v < 0 || v >= lim) v = 0;
    end else if (lim > 0 && r < 85) begin
      v = $urandom_range(lim - 1);
    end else if (r < 92) begin
      v = ($urandom_range(1) != 0) ? lim : -1;
    end else begin
      v = $urandom;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic pix_cmd_t roll_cmd();
    pix_cmd_t c;
    int       r, nl, nc, cv;
    nl = clip(reg_layers, DEF_LAYERS);
    nc = reg_colors;
    r = $urandom_range(99);
    if (r < 40)      c.op = OP_LAYER_WRITE;
    else if (r < 48) c.op = OP_DIRECT_DRAW;
    else if (r < 62) c.op = OP_LAYER_READ;
    else if (r < 78) c.op = OP_COMP_READ;
    else if (r < 95) c.op = OP_OCC_READ;
    else             c.op = ($urandom_range(1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
    c.x = pick_coord(clip(reg_width, DEF_MAX_WIDTH));
    c.y = pick_coord(clip(reg_height, DEF_MAX_HEIGHT));
    if (nl > 0 && $urandom_range(99) < 85) c.layer = LAYER_W'($urandom_range(nl - 1));
    else c.layer = LAYER_W'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 12)                cv = -1;
    else if (r < 20)           cv = 255;
    else if (r < 80 && nc > 0) cv = $urandom_range(nc - 1);
    else if (r < 88)           cv = nc;  // first color out of range
    else                       cv = $urandom;
    c.color = cv[COLOR_W-1:0];
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: drive at falldown edge, accept at the rising edge where
  // valid is high and req_stall low. The model runs at that edge.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input pix_cmd_t c, input bit typed, input pix_reply_t typed_rsp);
    pix_reply_t p;
    while ($urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    op        <= c.op;
    x         <= c.x;
    y         <= c.y;
    layer     <= c.layer;
    color     <= c.color;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    p = composite_step(c);
    expected_replies.push_back(typed ? typed_rsp : p);
    @(negedge clk);
  endtask

  // hold the sender until every reply word is back
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (expected_replies.size() != 0);
  endtask

  // four back-to-back register writes, only while the block is idle
  task automatic write_regs(int w, int h, int nc, int nl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACTIVE_WIDTH;
    cfg_data  <= w[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_ACTIVE_HEIGHT;
    cfg_data  <= h[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_NUM_COLORS;
    cfg_data  <= nc[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_NUM_LAYERS;
    cfg_data  <= nl[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we     <= 1'b0;
    reg_width  = w & 10'h3FF;
    reg_height = h & 10'h3FF;
    reg_colors = nc & 9'h1FF;
    reg_layers = nl & 4'hF;
  endtask

  // --------------------------------------------------------------------------
  // Reply side: random stall per phase, plus one long hold on request so the
  // block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : rsp_side
    int n;
    forever begin
      @(negedge clk);
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        for (n = 0; n < RSP_HOLD_CYCLES; n++) begin
          rsp_stall <= 1'b1;
          @(negedge clk);
        end
      end
      rsp_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  // reply checker: oldest expectation against each accepted word
  always @(posedge clk) begin : rsp_check
    pix_reply_t got, want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = '{status, read_value, draw_valid, draw_x, draw_y, draw_color, clear_display};
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply word at %0t", $time);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.draw_valid !== want.draw_valid || got.draw_x !== want.draw_x ||
            got.draw_y !== want.draw_y || got.draw_color !== want.draw_color ||
            got.clear_display !== want.clear_display) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp st=%0d rv=%h dv=%0d dx=%0d dy=%0d dc=%0d clr=%0d",
                     $time, want.status, want.read_value, want.draw_valid, want.draw_x,
                     want.draw_y, want.draw_color, want.clear_display);
            $display("  got st=%0d rv=%h dv=%0d dx=%0d dy=%0d dc=%0d clr=%0d",
                     got.status, got.read_value, got.draw_valid, got.draw_x, got.draw_y,
                     got.draw_color, got.clear_display);
          end
        end
      end
    end
  end

  // run length guard
  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("tb_top failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t   dir_rows [$];
    idle_mode_t mode;
    int         ph, k, n_items, w, h, nc, nl;

    // Directed table, reset register values (512 x 512, 256 colors, 8 layers).
    // Fresh pixels: blank composite, transparent layer, empty occupancy.
    dir_rows.push_back('{mk_cmd(OP_COMP_READ, 0, 0, 0, 0), 1'b1, mk_reply(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_LAYER_READ, 511, 511, 7, 0), 1'b1,
                         mk_reply(VALUE_TRANSP, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_OCC_READ, 511, 0, 0, 0), 1'b1, mk_reply(0, 0, 0, 0, 0, 0)});
    // first opaque pixel on a blank shadow draws
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, 0, 0, 5), 1'b1, mk_reply(0, 1, 0, 0, 5, 0)});
    // stacking on one pixel: top layer wins, lower writes hidden, erase reveals
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, 0, 7, 254), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, 0, 3, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_OCC_READ, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, 0, 7, -1), 1'b0, '0});
    // color 255 written as a color reads back as transparent
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, 0, 3, 255), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_LAYER_READ, 0, 0, 3, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_COMP_READ, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 511, 511, 7, 255), 1'b0, '0});
    // direct draw at the far corner, shadow untouched
    dir_rows.push_back('{mk_cmd(OP_DIRECT_DRAW, 511, 511, 0, 255), 1'b1,
                         mk_reply(0, 1, 511, 511, 255, 0)});
    dir_rows.push_back('{mk_cmd(OP_DIRECT_DRAW, 0, 0, 0, 0), 1'b0, '0});
    // range errors and undefined opcodes
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 512, 0, 0, 1), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 0, -1, 0, 1), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_COMP_READ, -1024, 1023, 0, 0), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 1, 1, 8, 1), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_LAYER_READ, 1, 1, 15, 0), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 1, 1, 0, -2), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_LAYER_WRITE, 1, 1, 0, -256), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_DIRECT_DRAW, 2, 2, 0, -1), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_OCC_READ, 1023, 0, 0, 0), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_UNDEF_LO, 0, 0, 0, 0), 1'b1, ERR_REPLY});
    dir_rows.push_back('{mk_cmd(OP_UNDEF_HI, 0, 0, 0, 0), 1'b1, ERR_REPLY});
    // clear after a direct draw blanks the display too, then all is fresh
    dir_rows.push_back('{mk_cmd(OP_CLEAR, 0, 0, 0, 0), 1'b1, mk_reply(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{mk_cmd(OP_COMP_READ, 0, 0, 0, 0), 1'b1, mk_reply(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_LAYER_READ, 0, 0, 0, 0), 1'b1,
                         mk_reply(VALUE_TRANSP, 0, 0, 0, 0, 0)});

    // release reset; the block then sweeps its RAM with req_stall up
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].reply);
    drain();

    // random phases, one register setting and one idle pattern each
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin w = 512;  h = 512;  nc = 256; nl = 8;  end  // reset values
        1: begin w = 1;    h = 1;    nc = 2;   nl = 1;  end  // minimum
        2: begin w = 1023; h = 1023; nc = 511; nl = 15; end  // beyond the caps
        3: begin w = 0;    h = 0;    nc = 0;   nl = 0;  end  // nothing in range
        8: begin w = 512;  h = 512;  nc = 256; nl = 8;  end
        default: begin
          w  = ($urandom_range(2) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 24);
          h  = ($urandom_range(2) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 24);
          nc = $urandom_range(2, 300);
          nl = $urandom_range(1, 10);
        end
      endcase
      write_regs(w, h, nc, nl);
      mode    = idle_mode_t'(ph % 4);
      snd_pct = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 7 : 0;
      rcv_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 7 : 0;
      n_items = (ph == 3) ? 30 : 150;
      for (k = 0; k < n_items; k++) begin
        // long reply hold while requests keep coming
        if (ph == 0 && k == 20) hold_rsp_req = 1'b1;
        // sender waits for the block to empty mid-phase
        if (ph == 4 && k == 75) drain();
        // one clear among the random traffic; it walks the whole RAM
        if (ph == 5 && k == 75) send_cmd(mk_cmd(OP_CLEAR, 0, 0, 0, 0), 1'b0, '0);
        send_cmd(roll_cmd(), 1'b0, '0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += expected_replies.size();
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
